@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the comet chase block. With SYNTHESIS
// defined they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rst, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg)

`endif

`endif

@@ src/cmc_pkg.sv @@
// ----------------------------------------------------------------------------
// Comet chase package
// Field widths, register codes, sequencer states and the structs shared by
// the divider, the sequencer and the top level.
// ----------------------------------------------------------------------------
package cmc_pkg;

  // field widths
  localparam int START_W    = 10;
  localparam int LEN_W      = 11;
  localparam int TRAIL_W    = 5;
  localparam int LEVEL_W    = 8;
  localparam int IDX_OUT_W  = 10;
  localparam int NUM_CH     = 4;
  localparam int COLOR_W    = NUM_CH * LEVEL_W;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 3;

  // shared divider: dividend covers 255*d^2 (d < 32) and start + offset sums
  localparam int DIV_W     = 2 * TRAIL_W + LEVEL_W;
  localparam int DVS_W     = LEN_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // parameter defaults
  localparam int DEF_MAX_PIXELS = 1024;
  localparam int DEF_MAX_TRAIL  = 16;

  localparam logic [LEVEL_W-1:0] FULL_FADE = 8'd255;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RING_START   = 3'd0,
    REG_RING_LENGTH  = 3'd1,
    REG_STRIP_PIXELS = 3'd2,
    REG_TRAIL_LENGTH = 3'd3,
    REG_RED_LEVEL    = 3'd4,
    REG_GREEN_LEVEL  = 3'd5,
    REG_BLUE_LEVEL   = 3'd6,
    REG_WHITE_LEVEL  = 3'd7
  } cfg_reg_t;

  // channel slots in level[]: packed order matches the color word
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;
  localparam int CH_WHITE = 3;

  typedef struct packed {
    logic [START_W-1:0]               ring_start;
    logic [LEN_W-1:0]                 ring_length;
    logic [LEN_W-1:0]                 strip_pixels;
    logic [TRAIL_W-1:0]               trail_length;
    logic [NUM_CH-1:0][LEVEL_W-1:0]   level;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POS_WAIT,
    S_BASE_WAIT,
    S_WRAP_WAIT,
    S_HEAD_WAIT,
    S_WIPE,
    S_ADVANCE,
    S_FADE,
    S_FADE_WAIT,
    S_SCALE,
    S_EMIT
  } seq_state_t;

  // floor(x / 255), exact for x < 65280, which covers any product of two 8-bit values
  function automatic logic [LEVEL_W-1:0] div255(input logic [2*LEVEL_W-1:0] x);
    logic [2*LEVEL_W:0] s;
    s = {1'b0, x} + {{(LEVEL_W+1){1'b0}}, x[2*LEVEL_W-1:LEVEL_W]} + (2*LEVEL_W+1)'(1);
    return s[2*LEVEL_W-1:LEVEL_W];
  endfunction

endpackage

@@ src/cmc_div.sv @@
// ----------------------------------------------------------------------------
// Comet chase shared divider
// Restoring divider, one quotient bit per cycle. Serves every modulo and
// the fade division of the sequencer.
// ----------------------------------------------------------------------------
module cmc_div
  import cmc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] steps;
  logic [DVS_W-1:0]     rem;
  logic [DVS_W-1:0]     dvs;
  logic [DIV_W-1:0]     quo;
  logic [DVS_W:0]       trial;
  logic                 fits;

  // shift one dividend bit into the partial remainder
  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy  <= 1'b1;
        steps <= DIV_CNT_W'(DIV_W);
        quo   <= req.dividend;
        rem   <= '0;
        dvs   <= req.divisor;
      end else if (busy) begin
        rem   <= fits ? DVS_W'(trial - {1'b0, dvs}) : DVS_W'(trial);
        quo   <= {quo[DIV_W-2:0], fits};
        steps <= steps - DIV_CNT_W'(1);
        if (steps == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, quotient: quo, remainder: rem};

endmodule

@@ src/cmc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Comet chase sequencer
// Runs one tick: head and index modulos on the shared divider, the wipe
// pass, the head advance and the fading draw pass, one beat per pixel.
// ----------------------------------------------------------------------------
module cmc_ctrl
  import cmc_pkg::*;
#(
  parameter int MAX_PIXELS = DEF_MAX_PIXELS,
  parameter int MAX_TRAIL  = DEF_MAX_TRAIL
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 tick_valid,
  output logic                 tick_stall,
  input  logic                 tick,
  output logic                 pixel_valid,
  input  logic                 pixel_stall,
  output logic [IDX_OUT_W-1:0] pixel_index,
  output logic [COLOR_W-1:0]   pixel_color,
  output logic                 last_write
);

  // clamp limits, bounded by what the register fields can hold
  localparam int LEN_CAP   = (MAX_PIXELS > 2**LEN_W - 1) ? 2**LEN_W - 1 : MAX_PIXELS;
  localparam int TRAIL_CAP = (MAX_TRAIL > 2**TRAIL_W - 1) ? 2**TRAIL_W - 1 : MAX_TRAIL;
  localparam int POS_W     = $clog2(LEN_CAP);
  localparam logic [LEN_W-1:0]   LEN_CAP_V   = LEN_W'(LEN_CAP);
  localparam logic [TRAIL_W-1:0] TRAIL_CAP_V = TRAIL_W'(TRAIL_CAP);

  seq_state_t state, state_next;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  logic [POS_W-1:0]     head_position;
  logic [POS_W-1:0]     pos;
  logic [POS_W-1:0]     off;
  logic [POS_W-1:0]     idx;
  logic [POS_W-1:0]     base_idx;
  logic [POS_W-1:0]     wrap_idx;
  logic [POS_W-1:0]     head_idx;
  logic [TRAIL_W-1:0]   cnt;
  logic [LEVEL_W-1:0]   fade;
  logic [2*TRAIL_W-1:0] trail_sq;
  logic [NUM_CH-1:0][2*LEVEL_W-1:0] prod;

  logic [IDX_OUT_W-1:0] out_index;
  logic [COLOR_W-1:0]   out_color;
  logic                 out_last;

  logic [LEN_W-1:0]     len_c;
  logic [LEN_W-1:0]     strip_c;
  logic [TRAIL_W-1:0]   trail_c;
  logic [TRAIL_W-1:0]   trail_m1;
  logic [TRAIL_W-1:0]   tail_d;
  logic [2*TRAIL_W-1:0] tail_d_sq;
  logic [DIV_W-1:0]     fade_num;
  logic [POS_W-1:0]     off_dec;
  logic [POS_W-1:0]     idx_dec;
  logic                 pos_wrap;
  logic                 head_wrap;
  logic                 slot_free;
  logic                 beat_load;
  logic                 pass_end;
  logic [NUM_CH-1:0][LEVEL_W-1:0] chan;

  // clamped configuration
  always_comb begin
    if (cfg.ring_length == '0)          len_c = LEN_W'(1);
    else if (cfg.ring_length > LEN_CAP_V) len_c = LEN_CAP_V;
    else                                len_c = cfg.ring_length;

    if (cfg.strip_pixels == '0)          strip_c = LEN_W'(1);
    else if (cfg.strip_pixels > LEN_CAP_V) strip_c = LEN_CAP_V;
    else                                 strip_c = cfg.strip_pixels;

    if (cfg.trail_length == '0)            trail_c = TRAIL_W'(1);
    else if (cfg.trail_length > TRAIL_CAP_V) trail_c = TRAIL_CAP_V;
    else                                   trail_c = cfg.trail_length;
  end

  assign trail_m1 = trail_c - TRAIL_W'(1);
  assign pass_end = (cnt == trail_m1);

  // fade numerator 255 * d^2
  assign tail_d    = trail_m1 - cnt;
  assign tail_d_sq = tail_d * tail_d;
  assign fade_num  = {tail_d_sq, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, tail_d_sq};

  // step one pixel backward around the ring
  assign off_dec = (off == '0) ? POS_W'(len_c - LEN_W'(1)) : off - POS_W'(1);
  assign idx_dec = (off == '0) ? wrap_idx :
                   (idx == '0) ? POS_W'(strip_c - LEN_W'(1)) : idx - POS_W'(1);

  // head advance wraps
  assign pos_wrap  = (LEN_W'(pos) + LEN_W'(1)) == len_c;
  assign head_wrap = (LEN_W'(head_idx) + LEN_W'(1)) == strip_c;

  assign slot_free = !pixel_valid || !pixel_stall;
  assign beat_load = slot_free && (state == S_WIPE || state == S_EMIT);

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      chan[c] = div255(prod[c]);
    end
  end

  cmc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and divider requests
  always_comb begin
    state_next = state;
    div_req    = '0;
    tick_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (tick_valid && tick) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(head_position);
          div_req.divisor  = len_c;
          state_next       = S_POS_WAIT;
        end
      end
      S_POS_WAIT: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(cfg.ring_start);
          div_req.divisor  = strip_c;
          state_next       = S_BASE_WAIT;
        end
      end
      S_BASE_WAIT: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(cfg.ring_start) + DIV_W'(len_c) - DIV_W'(1);
          div_req.divisor  = strip_c;
          state_next       = S_WRAP_WAIT;
        end
      end
      S_WRAP_WAIT: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(cfg.ring_start) + DIV_W'(pos);
          div_req.divisor  = strip_c;
          state_next       = S_HEAD_WAIT;
        end
      end
      S_HEAD_WAIT: begin
        if (div_rsp.done) state_next = S_WIPE;
      end
      S_WIPE: begin
        if (slot_free && pass_end) state_next = S_ADVANCE;
      end
      S_ADVANCE: begin
        state_next = S_FADE;
      end
      S_FADE: begin
        if (trail_c == TRAIL_W'(1)) begin
          state_next = S_SCALE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = fade_num;
          div_req.divisor  = DVS_W'(trail_sq);
          state_next       = S_FADE_WAIT;
        end
      end
      S_FADE_WAIT: begin
        if (div_rsp.done) state_next = S_SCALE;
      end
      S_SCALE: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) state_next = pass_end ? S_IDLE : S_FADE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      head_position <= '0;
      pixel_valid   <= 1'b0;
    end else begin
      if (beat_load) pixel_valid <= 1'b1;
      else if (pixel_valid && !pixel_stall) pixel_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          trail_sq <= trail_m1 * trail_m1;
        end
        S_POS_WAIT: begin
          if (div_rsp.done) pos <= POS_W'(div_rsp.remainder);
        end
        S_BASE_WAIT: begin
          if (div_rsp.done) base_idx <= POS_W'(div_rsp.remainder);
        end
        S_WRAP_WAIT: begin
          if (div_rsp.done) wrap_idx <= POS_W'(div_rsp.remainder);
        end
        S_HEAD_WAIT: begin
          if (div_rsp.done) begin
            idx      <= POS_W'(div_rsp.remainder);
            head_idx <= POS_W'(div_rsp.remainder);
            off      <= pos;
            cnt      <= '0;
          end
        end
        S_WIPE: begin
          if (slot_free) begin
            out_index   <= IDX_OUT_W'(idx);
            out_color   <= '0;
            out_last    <= 1'b0;
            off         <= off_dec;
            idx         <= idx_dec;
            cnt         <= cnt + TRAIL_W'(1);
          end
        end
        S_ADVANCE: begin
          cnt <= '0;
          if (pos_wrap) begin
            pos           <= '0;
            off           <= '0;
            head_position <= '0;
            idx           <= base_idx;
          end else begin
            pos           <= pos + POS_W'(1);
            off           <= pos + POS_W'(1);
            head_position <= pos + POS_W'(1);
            idx           <= head_wrap ? '0 : head_idx + POS_W'(1);
          end
        end
        S_FADE: begin
          if (trail_c == TRAIL_W'(1)) fade <= FULL_FADE;
        end
        S_FADE_WAIT: begin
          if (div_rsp.done) fade <= div_rsp.quotient[LEVEL_W-1:0];
        end
        S_SCALE: begin
          for (int c = 0; c < NUM_CH; c++) begin
            prod[c] <= cfg.level[c] * fade;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_index   <= IDX_OUT_W'(idx);
            out_color   <= {chan[CH_WHITE], chan[CH_RED], chan[CH_GREEN], chan[CH_BLUE]};
            out_last    <= pass_end;
            off         <= off_dec;
            idx         <= idx_dec;
            cnt         <= cnt + TRAIL_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign pixel_index = out_index;
  assign pixel_color = out_color;
  assign last_write  = out_last;

endmodule

@@ src/led_ring_comet_chase.sv @@
// ----------------------------------------------------------------------------
// LED ring comet chase
// Each tick wipes the previous comet trail and draws it one pixel further
// around a ring segment of the strip, with a quadratic fade along the tail.
//
//   channel  direction  handshake              payload
//   tick     in         tick_valid/tick_stall  tick
//   pixel    out        pixel_valid/pixel_stall pixel_index, pixel_color,
//                                              last_write
//   config   in         cfg_write              cfg_index, cfg_data
//
// A tick of trail length L runs, in order: four modulo runs on the shared
// divider, L wipe beats, a head advance and, per drawn pixel, a fade divide,
// a scale step and an emit beat; with L of 1 the fade divide is skipped.
// Synchronous reset clears the head position and restores config defaults.
// A pixel stall holds the sequencer in its wipe and emit beats; no tick is
// taken until the final beat of a tick is registered.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module led_ring_comet_chase
  import cmc_pkg::*;
#(
  parameter int MAX_PIXELS = DEF_MAX_PIXELS,
  parameter int MAX_TRAIL  = DEF_MAX_TRAIL
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick_valid,
  output logic                  tick_stall,
  input  logic                  tick,
  output logic                  pixel_valid,
  input  logic                  pixel_stall,
  output logic [IDX_OUT_W-1:0]  pixel_index,
  output logic [COLOR_W-1:0]    pixel_color,
  output logic                  last_write,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ring_start      <= '0;
      cfg.ring_length     <= LEN_W'(16);
      cfg.strip_pixels    <= LEN_W'(16);
      cfg.trail_length    <= TRAIL_W'(4);
      cfg.level[CH_RED]   <= FULL_FADE;
      cfg.level[CH_GREEN] <= '0;
      cfg.level[CH_BLUE]  <= '0;
      cfg.level[CH_WHITE] <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RING_START:   cfg.ring_start      <= cfg_data[START_W-1:0];
        REG_RING_LENGTH:  cfg.ring_length     <= cfg_data[LEN_W-1:0];
        REG_STRIP_PIXELS: cfg.strip_pixels    <= cfg_data[LEN_W-1:0];
        REG_TRAIL_LENGTH: cfg.trail_length    <= cfg_data[TRAIL_W-1:0];
        REG_RED_LEVEL:    cfg.level[CH_RED]   <= cfg_data[LEVEL_W-1:0];
        REG_GREEN_LEVEL:  cfg.level[CH_GREEN] <= cfg_data[LEVEL_W-1:0];
        REG_BLUE_LEVEL:   cfg.level[CH_BLUE]  <= cfg_data[LEVEL_W-1:0];
        REG_WHITE_LEVEL:  cfg.level[CH_WHITE] <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  cmc_ctrl #(
    .MAX_PIXELS (MAX_PIXELS),
    .MAX_TRAIL  (MAX_TRAIL)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .tick_valid  (tick_valid),
    .tick_stall  (tick_stall),
    .tick        (tick),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_index (pixel_index),
    .pixel_color (pixel_color),
    .last_write  (last_write)
  );

  // a live tick keeps the block busy
  `ASSERT_NEXT(a_busy_after_tick, clk, rst, tick_valid && !tick_stall && tick, tick_stall, "tick taken but block not busy")
  // nothing follows the final beat of a tick
  `ASSERT_NEXT(a_quiet_after_last, clk, rst, pixel_valid && !pixel_stall && last_write, !pixel_valid, "beat after final write")
  // once idle, only the final beat may still be pending
  `ASSERT_IMPLY(a_idle_holds_last, clk, rst, pixel_valid && !tick_stall, last_write, "idle with a non-final beat pending")

endmodule
